// ----- hdl/apm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// apm_pkg
// Shared types, dB threshold table and palette constants for the audio peak
// level meter.
// ----------------------------------------------------------------------------
package apm_pkg;

    // tracker weights: avg (15*a+m)/16, slow peak (63*p+a)/64, fast (7*p+a)/8
    localparam logic [4:0] AVG_WEIGHT  = 5'd15;
    localparam logic [6:0] SLOW_WEIGHT = 7'd63;
    localparam logic [3:0] FAST_WEIGHT = 4'd7;

    // last table index (deepest dB step) and width of an attenuation step count
    localparam int DB_STEPS = 40;
    localparam int ATTEN_W  = 6;

    // threshold table, entry d is the level that stands for -d dB
    localparam logic [15:0] DB_THRESH [0:DB_STEPS] = '{
        16'h7fff, 16'h7213, 16'h65ab, 16'h5a9d, 16'h50c2, 16'h47fa, 16'h4026,
        16'h392c, 16'h32f4, 16'h2d6a, 16'h2879, 16'h2412, 16'h2026, 16'h1ca7,
        16'h1989, 16'h16c2, 16'h1449, 16'h1214, 16'h101d, 16'h0e5c, 16'h0ccc,
        16'h0b68, 16'h0a2a, 16'h090f, 16'h0813, 16'h0732, 16'h066a, 16'h05b7,
        16'h0518, 16'h048a, 16'h040c, 16'h039b, 16'h0337, 16'h02dd, 16'h028d,
        16'h0246, 16'h0207, 16'h01ce, 16'h019c, 16'h016f, 16'h0147
    };

    // color breakpoints, as attenuation in dB (level below -N dB)
    localparam logic [ATTEN_W-1:0] ATTEN_LOW  = 6'd25;
    localparam logic [ATTEN_W-1:0] ATTEN_MID  = 6'd12;
    localparam logic [ATTEN_W-1:0] ATTEN_HIGH = 6'd3;

    // bar palette indexes
    localparam logic [7:0] BAR_IDX_LOW  = 8'h2F;
    localparam logic [7:0] BAR_IDX_MID  = 8'h06;
    localparam logic [7:0] BAR_IDX_HIGH = 8'h0F;
    localparam logic [7:0] BAR_IDX_CLIP = 8'h0C;

    // peak marker palette indexes
    localparam logic [7:0] MARK_COLOR_LOW  = 8'h0B;
    localparam logic [7:0] MARK_COLOR_HIGH = 8'h0F;
    localparam logic [7:0] MARK_COLOR_CLIP = 8'h08;

    // updated tracker values of one channel
    typedef struct packed {
        logic [15:0] avg;
        logic [15:0] peak;
        logic [15:0] fast_peak;
    } levels_t;

    // attenuation in whole dB: the deepest step whose threshold is above level
    function automatic logic [ATTEN_W-1:0] atten_db(input logic [15:0] level);
        logic [ATTEN_W-1:0] steps;
        steps = '0;
        for (int d = 1; d <= DB_STEPS; d++) begin
            if (DB_THRESH[d] > level) begin
                steps = ATTEN_W'(d);
            end
        end
        return steps;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/apm_tracker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// apm_tracker
// Per-channel average, slow peak and fast peak trackers with their update
// arithmetic; state is written when an update is committed.
// ----------------------------------------------------------------------------
module apm_tracker import apm_pkg::*; #(
    parameter int NUM_CHANNELS = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        update,
    input  wire logic        channel,
    input  wire logic [15:0] sample,
    output levels_t          levels
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [15:0] avg_reg       [NUM_CHANNELS];
    logic [15:0] peak_reg      [NUM_CHANNELS];
    logic [15:0] fast_peak_reg [NUM_CHANNELS];

    logic [CH_W-1:0] ch_idx;
    logic [15:0]     mag;
    logic [15:0]     avg_old;
    logic [15:0]     peak_raised;
    logic [15:0]     fast_raised;
    logic [19:0]     avg_sum;
    logic [21:0]     peak_sum;
    logic [18:0]     fast_sum;

    // channel wraps onto the configured channel count
    assign ch_idx = (NUM_CHANNELS == 1) ? '0 : CH_W'(channel);

    // magnitude, -32768 maps to 0x8000
    assign mag = sample[15] ? (~sample + 16'd1) : sample;

    // running average
    assign avg_old = avg_reg[ch_idx];
    assign avg_sum = 20'(avg_old) * 20'(AVG_WEIGHT) + 20'(mag);

    // peaks raised to the magnitude, then decayed toward the new average
    assign peak_raised = (mag > peak_reg[ch_idx]) ? mag : peak_reg[ch_idx];
    assign fast_raised = (mag > fast_peak_reg[ch_idx]) ? mag : fast_peak_reg[ch_idx];

    always_comb begin
        levels.avg       = avg_sum[19:4];
        peak_sum         = 22'(peak_raised) * 22'(SLOW_WEIGHT) + 22'(levels.avg);
        fast_sum         = 19'(fast_raised) * 19'(FAST_WEIGHT) + 19'(levels.avg);
        levels.peak      = peak_sum[21:6];
        levels.fast_peak = fast_sum[18:3];
    end

    // tracker state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                avg_reg[i]       <= '0;
                peak_reg[i]      <= '0;
                fast_peak_reg[i] <= '0;
            end
        end else if (update) begin
            avg_reg[ch_idx]       <= levels.avg;
            peak_reg[ch_idx]      <= levels.peak;
            fast_peak_reg[ch_idx] <= levels.fast_peak;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/apm_level.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// apm_level
// Converts the updated peaks to whole dB through the threshold table and
// picks the bar and peak marker palette indexes.
// ----------------------------------------------------------------------------
module apm_level import apm_pkg::*; (
    input  wire levels_t      levels,
    output logic signed [6:0] db_peak,
    output logic signed [6:0] db_fast,
    output logic [7:0]       bar_idx,
    output logic [7:0]       mark_idx
);

    logic [ATTEN_W-1:0] atten_slow;
    logic [ATTEN_W-1:0] atten_fast;

    // table lookups
    assign atten_slow = atten_db(levels.peak);
    assign atten_fast = atten_db(levels.fast_peak);

    // dB is the negated attenuation
    assign db_peak = 7'sd0 - $signed({1'b0, atten_slow});
    assign db_fast = 7'sd0 - $signed({1'b0, atten_fast});

    // bar color by fast peak
    always_comb begin
        if (atten_fast > ATTEN_LOW) begin
            bar_idx = BAR_IDX_LOW;
        end else if (atten_fast > ATTEN_MID) begin
            bar_idx = BAR_IDX_MID;
        end else if (atten_fast > ATTEN_HIGH) begin
            bar_idx = BAR_IDX_HIGH;
        end else begin
            bar_idx = BAR_IDX_CLIP;
        end
    end

    // peak marker color by slow peak
    always_comb begin
        if (atten_slow > ATTEN_MID) begin
            mark_idx = MARK_COLOR_LOW;
        end else if (atten_slow > ATTEN_HIGH) begin
            mark_idx = MARK_COLOR_HIGH;
        end else begin
            mark_idx = MARK_COLOR_CLIP;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/audio_peak_level_meter.sv -----
`default_nettype none
// path: a sample accepted on s_axis passes the input register, then the result
//   register, before its result shows on m_axis
// throughput: one sample per cycle while m_axis takes results, as the tracker
//   update is combinational between the input register and the result register
// back-pressure on m_axis stalls the pipe; s_axis stays ready while a slot frees
// reset: synchronous active-low, clears all trackers to zero and drops valids
// ----------------------------------------------------------------------------
// audio_peak_level_meter
// Per-channel running average with slow and fast decaying peak hold, dB
// conversion and palette color selection for a level meter display.
// ----------------------------------------------------------------------------
module audio_peak_level_meter import apm_pkg::*; #(
    parameter int NUM_CHANNELS = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
    input  wire logic [0:0]  s_axis_tuser,   // [0] channel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] level_avg, [31:16] level_peak, [47:32] fast peak level,
    // [54:48] db_peak, [61:55] fast peak dB, [69:62] bar palette index,
    // [77:70] peak marker palette index, [79:78] zero
    output logic [79:0]      m_axis_tdata
);

    logic        in_valid_reg;
    logic        in_channel_reg;
    logic [15:0] in_sample_reg;
    logic        out_valid_reg;
    logic [79:0] out_data_reg;
    logic [79:0] out_data_next;
    logic        advance;

    levels_t          levels;
    logic signed [6:0] db_peak;
    logic signed [6:0] db_fast;
    logic [7:0]       bar_idx;
    logic [7:0]       mark_idx;

    // handshake
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_channel_reg <= s_axis_tuser[0];
            in_sample_reg  <= s_axis_tdata;
        end
    end

    // tracker update
    apm_tracker #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .update  (advance),
        .channel (in_channel_reg),
        .sample  (in_sample_reg),
        .levels  (levels)
    );

    // dB and colors
    apm_level u_level (
        .levels   (levels),
        .db_peak  (db_peak),
        .db_fast  (db_fast),
        .bar_idx  (bar_idx),
        .mark_idx (mark_idx)
    );

    // result packing
    assign out_data_next = {2'b00, mark_idx, bar_idx, db_fast, db_peak,
                            levels.fast_peak, levels.peak, levels.avg};

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
`default_nettype wire
